### rtl/core/xbp_pkg.sv
// Shared types, constants and helpers for the xxHash64 block random generator.
`timescale 1ns / 1ps
`default_nettype none
package xbp_pkg;

    localparam int STATE_WORDS_N_DEF = 8;
    localparam int OUT_MULT_DEF      = 8;
    localparam int STATE_DEPTH       = 8;
    localparam int SEED_W            = 7;

    localparam logic [SEED_W-1:0] SEED_BASE = 7'd42;

    localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;

    localparam logic [1:0] ACT_SEED = 2'd0;
    localparam logic [1:0] ACT_LOAD = 2'd1;
    localparam logic [1:0] ACT_GEN  = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD_STATE,
        OP_INIT_LONG,
        OP_INIT_SHORT,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_ACC_ADDROT,
        OP_ACC_LOADP,
        OP_MERGE,
        OP_T_ROT,
        OP_H_XORP,
        OP_H_ADDP4,
        OP_H_ADDLEN,
        OP_H_ROT27,
        OP_H_SHX33,
        OP_H_SHX29P,
        OP_H_FINAL,
        OP_STORE_STATE,
        OP_STORE_XBUF,
        OP_COMMIT,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        X_WORD,
        X_ACC,
        X_T,
        X_H
    } xsel_t;

    typedef enum logic [1:0] {
        C_PR1,
        C_PR2,
        C_PR3
    } csel_t;

    typedef struct packed {
        op_t               op;
        xsel_t             xsel;
        csel_t             csel;
        logic [1:0]        lane;
        logic [2:0]        widx;
        logic [SEED_W-1:0] hseed;
        logic [3:0]        nwords;
        logic [5:0]        number;
        logic              last;
    } cmd_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

endpackage
`default_nettype wire

### rtl/core/xxhash64_block_prng_unit.sv
// Top level of the xxHash64 block random generator: controller plus datapath.
//
// Random generator over STATE_WORDS_N 64-bit state words, built on xxHash64.
// A seed word (action 0) sets state word 0 to word_value and word i to XXH64
// of that value with hash seed 42+i; a load word (action 1) writes one raw
// state word, out-of-range indexes and action 3 are ignored. A generate word
// (action 2) hashes the whole state OUT_MULT*STATE_WORDS_N times with hash
// seeds 0,1,..; the first STATE_WORDS_N hashes are XORed into the state and
// the rest leave on the output channel in order, last_word marking the final
// one. All hashing runs on one shared datapath with a 64-bit multiplier built
// from one 32x32 partial product per cycle. Load words are written straight
// from the idle state without raising input stall. Input stall is high while
// a seed or generate word is being worked; a finished output word waits in
// its register, and a full, stalled output register holds up the next hash.
`timescale 1ns / 1ps
`default_nettype none
module xxhash64_block_prng_unit #(
    parameter int STATE_WORDS_N = xbp_pkg::STATE_WORDS_N_DEF,
    parameter int OUT_MULT      = xbp_pkg::OUT_MULT_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [1:0]  action,
    input  wire  [2:0]  word_index,
    input  wire  [63:0] word_value,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [63:0] rand_word,
    output logic [5:0]  word_number,
    output logic        last_word
);
    import xbp_pkg::*;

    cmd_t cmd;

    xbp_ctrl #(
        .STATE_WORDS_N (STATE_WORDS_N),
        .OUT_MULT      (OUT_MULT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .word_index (word_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cmd        (cmd)
    );

    xbp_datapath #(
        .STATE_WORDS_N (STATE_WORDS_N)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .word_value  (word_value),
        .rand_word   (rand_word),
        .word_number (word_number),
        .last_word   (last_word)
    );

endmodule
`default_nettype wire

### rtl/core/xbp_datapath.sv
// Datapath: state words, hash lanes, split 64-bit multiplier and output word register.
`timescale 1ns / 1ps
`default_nettype none
module xbp_datapath #(
    parameter int STATE_WORDS_N = xbp_pkg::STATE_WORDS_N_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire  xbp_pkg::cmd_t   cmd,
    input  wire  [63:0]           word_value,
    output logic [63:0]           rand_word,
    output logic [5:0]            word_number,
    output logic                  last_word
);
    import xbp_pkg::*;

    logic [63:0] state_reg [STATE_DEPTH];
    logic [63:0] state_next [STATE_DEPTH];
    logic [63:0] xbuf_reg [STATE_DEPTH];
    logic [63:0] acc_reg [4];
    logic [63:0] acc_next [4];
    logic [63:0] h_reg, h_next, t_reg, t_next;
    logic [63:0] x_reg, x_next, c_reg, c_next, p_reg, p_next;
    logic [63:0] xv, cv, seed64, prod;
    logic [63:0] rw_reg;
    logic [5:0]  num_reg;
    logic        last_reg;

    assign seed64 = 64'(cmd.hseed);

    always_comb
    begin
        unique case (cmd.xsel)
            X_WORD:  xv = state_reg[cmd.widx];
            X_ACC:   xv = acc_reg[cmd.lane];
            X_T:     xv = t_reg;
            default: xv = h_reg;
        endcase
        unique case (cmd.csel)
            C_PR1:   cv = PR1;
            C_PR2:   cv = PR2;
            default: cv = PR3;
        endcase
    end

    // one 32x32 partial product per cycle
    always_comb
    begin
        unique case (cmd.op)
            OP_MUL0: prod = {32'b0, xv[31:0]} * {32'b0, cv[31:0]};
            OP_MUL1: prod = {32'b0, x_reg[31:0]} * {32'b0, c_reg[63:32]};
            default: prod = {32'b0, x_reg[63:32]} * {32'b0, c_reg[31:0]};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        h_next     = h_reg;
        t_next     = t_reg;
        x_next     = x_reg;
        c_next     = c_reg;
        p_next     = p_reg;
        unique case (cmd.op)
            OP_LOAD_STATE:  state_next[cmd.widx] = word_value;
            OP_INIT_LONG:
            begin
                acc_next[0] = seed64 + PR1 + PR2;
                acc_next[1] = seed64 + PR2;
                acc_next[2] = seed64;
                acc_next[3] = seed64 - PR1;
            end
            OP_INIT_SHORT:  h_next = seed64 + PR5;
            OP_MUL0:
            begin
                x_next = xv;
                c_next = cv;
                p_next = prod;
            end
            OP_MUL1, OP_MUL2: p_next = p_reg + {prod[31:0], 32'b0};
            OP_ACC_ADDROT:  acc_next[cmd.lane] = rotl64(acc_reg[cmd.lane] + p_reg, 31);
            OP_ACC_LOADP:   acc_next[cmd.lane] = p_reg;
            OP_MERGE:       h_next = rotl64(acc_reg[0], 1) + rotl64(acc_reg[1], 7)
                                   + rotl64(acc_reg[2], 12) + rotl64(acc_reg[3], 18);
            OP_T_ROT:       t_next = rotl64(p_reg, 31);
            OP_H_XORP:      h_next = h_reg ^ p_reg;
            OP_H_ADDP4:     h_next = p_reg + PR4;
            OP_H_ADDLEN:    h_next = h_reg + 64'({cmd.nwords, 3'b000});
            OP_H_ROT27:     h_next = rotl64(h_reg, 27);
            OP_H_SHX33:     h_next = h_reg ^ (h_reg >> 33);
            OP_H_SHX29P:    h_next = p_reg ^ (p_reg >> 29);
            OP_H_FINAL:     h_next = p_reg ^ (p_reg >> 32);
            OP_STORE_STATE: state_next[cmd.widx] = h_reg;
            OP_COMMIT:
            begin
                for (int i = 0; i < STATE_WORDS_N; i++)
                begin
                    state_next[i] = state_reg[i] ^ xbuf_reg[i];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STATE_DEPTH; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        h_reg   <= h_next;
        t_reg   <= t_next;
        x_reg   <= x_next;
        c_reg   <= c_next;
        p_reg   <= p_next;
        if (cmd.op == OP_STORE_XBUF)
        begin
            xbuf_reg[cmd.widx] <= h_reg;
        end
        if (cmd.op == OP_EMIT)
        begin
            rw_reg   <= h_reg;
            num_reg  <= cmd.number;
            last_reg <= cmd.last;
        end
    end

    assign rand_word   = rw_reg;
    assign word_number = num_reg;
    assign last_word   = last_reg;

endmodule
`default_nettype wire

### rtl/core/xbp_ctrl.sv
// Controller: sequences seeding, loading and block generation on the datapath.
`timescale 1ns / 1ps
`default_nettype none
module xbp_ctrl #(
    parameter int STATE_WORDS_N = xbp_pkg::STATE_WORDS_N_DEF,
    parameter int OUT_MULT      = xbp_pkg::OUT_MULT_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_stall,
    input  wire  [1:0]       action,
    input  wire  [2:0]       word_index,
    output logic             out_valid,
    input  wire              out_stall,
    output xbp_pkg::cmd_t    cmd
);
    import xbp_pkg::*;

    localparam int HASH_N = OUT_MULT * STATE_WORDS_N;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_INIT   = 10'b0000000010,
        S_STRIPE = 10'b0000000100,
        S_MERGE  = 10'b0000001000,
        S_FOLD   = 10'b0000010000,
        S_LEN    = 10'b0000100000,
        S_TAIL   = 10'b0001000000,
        S_AVAL   = 10'b0010000000,
        S_DONE   = 10'b0100000000,
        S_COMMIT = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [3:0]        step_reg, step_next;
    logic [1:0]        lane_reg, lane_next;
    logic [3:0]        pos_reg, pos_next;
    logic [SEED_W-1:0] cnt_reg, cnt_next;
    logic              gen_reg, gen_next;
    logic              ov_reg, ov_next;
    logic [3:0]        n_words;
    logic              long_hash;
    logic [4:0]        pos_sum;

    assign n_words   = gen_reg ? 4'(STATE_WORDS_N) : 4'd1;
    assign long_hash = n_words >= 4'd4;
    assign pos_sum   = {1'b0, pos_reg} + {3'b0, lane_reg};
    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        lane_next  = lane_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        gen_next   = gen_reg;
        ov_next    = (ov_reg && !out_stall) ? 1'b0 : ov_reg;

        cmd.op     = OP_NOP;
        cmd.xsel   = X_H;
        cmd.csel   = C_PR1;
        cmd.lane   = lane_reg;
        cmd.widx   = pos_sum[2:0];
        cmd.hseed  = gen_reg ? cnt_reg : SEED_BASE + cnt_reg;
        cmd.nwords = n_words;
        cmd.number = 6'(cnt_reg - SEED_W'(STATE_WORDS_N));
        cmd.last   = cnt_reg == SEED_W'(HASH_N - 1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (action == ACT_SEED)
                    begin
                        cmd.op     = OP_LOAD_STATE;
                        cmd.widx   = 3'd0;
                        gen_next   = 1'b0;
                        cnt_next   = SEED_W'(1);
                        state_next = S_INIT;
                    end
                    else if (action == ACT_LOAD)
                    begin
                        cmd.widx = word_index;
                        if (4'(word_index) < 4'(STATE_WORDS_N))
                        begin
                            cmd.op = OP_LOAD_STATE;
                        end
                    end
                    else if (action == ACT_GEN)
                    begin
                        gen_next   = 1'b1;
                        cnt_next   = '0;
                        state_next = S_INIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_INIT:
            begin
                cmd.op     = long_hash ? OP_INIT_LONG : OP_INIT_SHORT;
                pos_next   = '0;
                lane_next  = '0;
                step_next  = '0;
                state_next = long_hash ? S_STRIPE : S_LEN;
            end
            S_STRIPE:
            begin
                unique case (step_reg)
                    4'd0:    begin cmd.op = OP_MUL0; cmd.xsel = X_WORD; cmd.csel = C_PR2; end
                    4'd1:    cmd.op = OP_MUL1;
                    4'd2:    cmd.op = OP_MUL2;
                    4'd3:    cmd.op = OP_ACC_ADDROT;
                    4'd4:    begin cmd.op = OP_MUL0; cmd.xsel = X_ACC; cmd.csel = C_PR1; end
                    4'd5:    cmd.op = OP_MUL1;
                    4'd6:    cmd.op = OP_MUL2;
                    default: cmd.op = OP_ACC_LOADP;
                endcase
                if (step_reg == 4'd7)
                begin
                    step_next = '0;
                    lane_next = lane_reg + 2'd1;
                    if (lane_reg == 2'd3)
                    begin
                        pos_next = pos_reg + 4'd4;
                        if ({1'b0, pos_reg} + 5'd8 > {1'b0, n_words})
                        begin
                            state_next = S_MERGE;
                        end
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_MERGE:
            begin
                cmd.op     = OP_MERGE;
                lane_next  = '0;
                step_next  = '0;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                unique case (step_reg)
                    4'd0:    begin cmd.op = OP_MUL0; cmd.xsel = X_ACC; cmd.csel = C_PR2; end
                    4'd1:    cmd.op = OP_MUL1;
                    4'd2:    cmd.op = OP_MUL2;
                    4'd3:    cmd.op = OP_T_ROT;
                    4'd4:    begin cmd.op = OP_MUL0; cmd.xsel = X_T; cmd.csel = C_PR1; end
                    4'd5:    cmd.op = OP_MUL1;
                    4'd6:    cmd.op = OP_MUL2;
                    4'd7:    cmd.op = OP_H_XORP;
                    4'd8:    begin cmd.op = OP_MUL0; cmd.xsel = X_H; cmd.csel = C_PR1; end
                    4'd9:    cmd.op = OP_MUL1;
                    4'd10:   cmd.op = OP_MUL2;
                    default: cmd.op = OP_H_ADDP4;
                endcase
                if (step_reg == 4'd11)
                begin
                    step_next = '0;
                    lane_next = lane_reg + 2'd1;
                    if (lane_reg == 2'd3)
                    begin
                        state_next = S_LEN;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_LEN:
            begin
                cmd.op     = OP_H_ADDLEN;
                step_next  = '0;
                lane_next  = '0;
                state_next = (pos_reg < n_words) ? S_TAIL : S_AVAL;
            end
            S_TAIL:
            begin
                unique case (step_reg)
                    4'd0:    begin cmd.op = OP_MUL0; cmd.xsel = X_WORD; cmd.csel = C_PR2; end
                    4'd1:    cmd.op = OP_MUL1;
                    4'd2:    cmd.op = OP_MUL2;
                    4'd3:    cmd.op = OP_T_ROT;
                    4'd4:    begin cmd.op = OP_MUL0; cmd.xsel = X_T; cmd.csel = C_PR1; end
                    4'd5:    cmd.op = OP_MUL1;
                    4'd6:    cmd.op = OP_MUL2;
                    4'd7:    cmd.op = OP_H_XORP;
                    4'd8:    cmd.op = OP_H_ROT27;
                    4'd9:    begin cmd.op = OP_MUL0; cmd.xsel = X_H; cmd.csel = C_PR1; end
                    4'd10:   cmd.op = OP_MUL1;
                    4'd11:   cmd.op = OP_MUL2;
                    default: cmd.op = OP_H_ADDP4;
                endcase
                if (step_reg == 4'd12)
                begin
                    step_next = '0;
                    pos_next  = pos_reg + 4'd1;
                    if (pos_reg + 4'd1 >= n_words)
                    begin
                        state_next = S_AVAL;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_AVAL:
            begin
                unique case (step_reg)
                    4'd0:    cmd.op = OP_H_SHX33;
                    4'd1:    begin cmd.op = OP_MUL0; cmd.xsel = X_H; cmd.csel = C_PR2; end
                    4'd2:    cmd.op = OP_MUL1;
                    4'd3:    cmd.op = OP_MUL2;
                    4'd4:    cmd.op = OP_H_SHX29P;
                    4'd5:    begin cmd.op = OP_MUL0; cmd.xsel = X_H; cmd.csel = C_PR3; end
                    4'd6:    cmd.op = OP_MUL1;
                    4'd7:    cmd.op = OP_MUL2;
                    default: cmd.op = OP_H_FINAL;
                endcase
                if (step_reg == 4'd8)
                begin
                    step_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_DONE:
            begin
                cmd.widx = cnt_reg[2:0];
                if (!gen_reg)
                begin
                    cmd.op     = OP_STORE_STATE;
                    cnt_next   = cnt_reg + SEED_W'(1);
                    state_next = (cnt_reg == SEED_W'(STATE_WORDS_N - 1)) ? S_IDLE : S_INIT;
                end
                else if (cnt_reg < SEED_W'(STATE_WORDS_N))
                begin
                    cmd.op     = OP_STORE_XBUF;
                    cnt_next   = cnt_reg + SEED_W'(1);
                    state_next = S_INIT;
                end
                else if (!(ov_reg && out_stall))
                begin
                    // output register free or being taken this cycle
                    cmd.op     = OP_EMIT;
                    ov_next    = 1'b1;
                    cnt_next   = cnt_reg + SEED_W'(1);
                    state_next = cmd.last ? S_COMMIT : S_INIT;
                end
            end
            default:
            begin
                cmd.op     = OP_COMMIT;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            lane_reg  <= '0;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            gen_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            lane_reg  <= lane_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            gen_reg   <= gen_next;
            ov_reg    <= ov_next;
        end
    end

endmodule
`default_nettype wire

### verif/xxhash64_block_prng_unit_test.sv
// Self-checking testbench for the xxHash64 block random generator.
`timescale 1ns / 1ps
`default_nettype none
module xxhash64_block_prng_unit_test;
    import xbp_pkg::*;

    localparam int N_WORDS    = STATE_WORDS_N_DEF;
    localparam int N_HASHES   = OUT_MULT_DEF * N_WORDS;
    localparam int IDLE_LIMIT = 200000;

    // One expected output word.
    typedef struct {
        logic [63:0] value;
        logic [5:0]  number;
        logic        last;
    } rand_word_t;

    // Keeps its own copy of the generator state and the queue of pending words.
    class prng_scoreboard;
        logic [63:0] gen_words [N_WORDS];
        rand_word_t  pending [$];
        int          mismatches;

        function new();
            foreach (gen_words[i]) gen_words[i] = '0;
            mismatches = 0;
        endfunction

        static function logic [63:0] rot(logic [63:0] x, int r);
            return (x << r) | (x >> (64 - r));
        endfunction

        static function logic [63:0] round_lane(logic [63:0] acc, logic [63:0] lane);
            acc = acc + lane * PR2;
            return rot(acc, 31) * PR1;
        endfunction

        // Standard XXH64 over n little-endian 64-bit words.
        static function logic [63:0] xxh64_words(logic [63:0] w [N_WORDS], int n,
                                                 logic [63:0] hseed);
            logic [63:0] h, a1, a2, a3, a4;
            int p;
            p = 0;
            if (n >= 4) begin
                a1 = hseed + PR1 + PR2;
                a2 = hseed + PR2;
                a3 = hseed;
                a4 = hseed - PR1;
                while (p + 4 <= n) begin
                    a1 = round_lane(a1, w[p]);
                    a2 = round_lane(a2, w[p+1]);
                    a3 = round_lane(a3, w[p+2]);
                    a4 = round_lane(a4, w[p+3]);
                    p += 4;
                end
                h = rot(a1, 1) + rot(a2, 7) + rot(a3, 12) + rot(a4, 18);
                h = (h ^ round_lane(0, a1)) * PR1 + PR4;
                h = (h ^ round_lane(0, a2)) * PR1 + PR4;
                h = (h ^ round_lane(0, a3)) * PR1 + PR4;
                h = (h ^ round_lane(0, a4)) * PR1 + PR4;
            end else
                h = hseed + PR5;
            h = h + 64'(n * 8);
            while (p < n) begin
                h = h ^ round_lane(0, w[p]);
                h = rot(h, 27) * PR1 + PR4;
                p++;
            end
            h = h ^ (h >> 33);
            h = h * PR2;
            h = h ^ (h >> 29);
            h = h * PR3;
            h = h ^ (h >> 32);
            return h;
        endfunction

        function void note_word(logic [1:0] act, logic [2:0] idx, logic [63:0] val);
            logic [63:0] one [N_WORDS];
            logic [63:0] hashes [N_HASHES];
            rand_word_t  rw;
            if (act == ACT_SEED) begin
                foreach (one[i]) one[i] = '0;
                one[0] = val;
                gen_words[0] = val;
                for (int i = 1; i < N_WORDS; i++)
                    gen_words[i] = xxh64_words(one, 1, 64'(SEED_BASE) + 64'(i));
            end else if (act == ACT_LOAD) begin
                if (idx < N_WORDS) gen_words[idx] = val;
            end else if (act == ACT_GEN) begin
                for (int i = 0; i < N_HASHES; i++)
                    hashes[i] = xxh64_words(gen_words, N_WORDS, 64'(i));
                for (int i = 0; i < N_WORDS; i++)
                    gen_words[i] ^= hashes[i];
                for (int i = N_WORDS; i < N_HASHES; i++) begin
                    rw.value  = hashes[i];
                    rw.number = 6'(i - N_WORDS);
                    rw.last   = (i == N_HASHES - 1);
                    pending.push_back(rw);
                end
            end
        endfunction

        function void check_word(logic [63:0] v, logic [5:0] num, logic lst);
            rand_word_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected word %h #%0d last=%b", v, num, lst);
                return;
            end
            e = pending.pop_front();
            if (e.value !== v || e.number !== num || e.last !== lst) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: exp %h #%0d last=%b, got %h #%0d last=%b",
                             e.value, e.number, e.last, v, num, lst);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [1:0]  action = '0;
    logic [2:0]  word_index = '0;
    logic [63:0] word_value = '0;
    logic        out_stall = 1'b0;
    logic        in_stall, out_valid, last_word;
    logic [63:0] rand_word;
    logic [5:0]  word_number;

    prng_scoreboard sb = new();

    // Idle/stall percentages per phase; hold_off forces a long receiver stall.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    int idle_cycles = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    xxhash64_block_prng_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .word_index(word_index), .word_value(word_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .rand_word(rand_word), .word_number(word_number), .last_word(last_word)
    );

    // Receiver: check on accept, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(rand_word, word_number, last_word);
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: counts cycles with no word accepted on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("xxhash64_block_prng_unit_test failed");
            $finish;
        end
    end

    // Offer one input word and hold it until accepted; valid stays high
    // afterwards so that back-to-back words need no extra drive.
    task automatic send_word(logic [1:0] act, logic [2:0] idx, logic [63:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        word_index <= idx;
        word_value <= val;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(act, idx, val);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = '0;
            1: v = '1;
            2: v = 64'(1) << $urandom_range(63);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Random mix of seed, load and generate words, plus some unused-action noise.
    task automatic random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12)
            send_word(ACT_SEED, 3'($urandom), rand64());
        else if (pick < 40)
            send_word(ACT_LOAD, 3'($urandom), rand64());
        else if (pick < 90)
            send_word(ACT_GEN, 3'($urandom), rand64());
        else
            send_word(2'd3, 3'($urandom), rand64());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: generate from the all-zero state after reset.
        send_word(ACT_GEN, 3'd0, '0);
        // Unused action code is ignored.
        send_word(2'd3, 3'd7, '1);
        send_word(ACT_GEN, 3'd5, '1);
        // Seed extremes.
        send_word(ACT_SEED, 3'd7, '0);
        send_word(ACT_GEN, 3'd0, '0);
        send_word(ACT_SEED, 3'd0, '1);
        send_word(ACT_GEN, 3'd0, '0);
        send_word(ACT_SEED, 3'd2, 64'h8000_0000_0000_0001);
        // Raw loads into every word, alternating patterns.
        for (int i = 0; i < 8; i++)
            send_word(ACT_LOAD, 3'(i), (i % 2) ? 64'hAAAA_AAAA_AAAA_AAAA : '1);
        send_word(ACT_GEN, 3'd0, '0);
        send_word(ACT_LOAD, 3'd3, 64'h5555_5555_5555_5555);
        send_word(ACT_GEN, 3'd0, '0);
        wait_drained();

        // Words are sent back to back, while the receiver holds off
        // long enough that the output register fills and the input stalls.
        hold_off = 3000;
        send_word(ACT_GEN, 3'd0, '0);
        send_word(ACT_SEED, 3'd0, {$urandom, $urandom});
        send_word(ACT_GEN, 3'd0, '0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            repeat (70) random_word();
        end
        send_idle_pct = 0;
        wait_drained();
        repeat (200) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("xxhash64_block_prng_unit_test passed");
        else
            $display("xxhash64_block_prng_unit_test failed");
        $finish;
    end
endmodule
`default_nettype wire
